// ----- rtl/clscan_pkg.sv -----
`default_nettype none

package clscan_pkg;

    localparam int PHASE_BITS          = 32;
    localparam int ANGLE_FRACTION_BITS = 16;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int PAN_SH  = 46 - ANGLE_FRACTION_BITS;
    localparam int TILT_SH = 60 - ANGLE_FRACTION_BITS;

    localparam int SUM_W   = 56;
    localparam int SPEED_W = 28;
    localparam int DIVD_W  = 60;
    localparam int DCNT_W  = 6;

    localparam logic [31:0] Q30_ONE    = 32'd1073741824;
    localparam logic [29:0] PI4_Q30    = 30'd843314857;
    localparam logic [59:0] PI_Q32     = 60'd13493037705;
    localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
    localparam logic [31:0] C1_Q30     = 32'd1686629713;
    localparam logic [31:0] C3_Q30     = 32'd693598668;
    localparam logic [31:0] C5_Q30     = 32'd85569306;
    localparam logic [31:0] C7_Q30     = 32'd5026995;
    localparam logic [31:0] C9_Q30     = 32'd172272;

    localparam logic [19:0] TARGET_SPEED_RST   = 20'd65536;
    localparam logic [15:0] FRAME_PERIOD_RST   = 16'd1311;
    localparam logic [16:0] YAW_AMPLITUDE_RST  = 17'd68629;
    localparam logic [19:0] TILT_FREQUENCY_RST = 20'd197535;

    localparam logic [1:0] REG_TARGET_SPEED   = 2'd0;
    localparam logic [1:0] REG_FRAME_PERIOD   = 2'd1;
    localparam logic [1:0] REG_YAW_AMPLITUDE  = 2'd2;
    localparam logic [1:0] REG_TILT_FREQUENCY = 2'd3;

    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_USQ  = 5'd2;
    localparam logic [4:0] OP_U2   = 5'd3;
    localparam logic [4:0] OP_SMUL = 5'd4;
    localparam logic [4:0] OP_SSUB = 5'd5;
    localparam logic [4:0] OP_UMUL = 5'd6;
    localparam logic [4:0] OP_MAG  = 5'd7;
    localparam logic [4:0] OP_DXM  = 5'd8;
    localparam logic [4:0] OP_DX   = 5'd9;
    localparam logic [4:0] OP_KM   = 5'd10;
    localparam logic [4:0] OP_K    = 5'd11;
    localparam logic [4:0] OP_DYM  = 5'd12;
    localparam logic [4:0] OP_DY   = 5'd13;
    localparam logic [4:0] OP_XX   = 5'd14;
    localparam logic [4:0] OP_SUMX = 5'd15;
    localparam logic [4:0] OP_YY   = 5'd16;
    localparam logic [4:0] OP_SUMY = 5'd17;
    localparam logic [4:0] OP_SQRT = 5'd18;
    localparam logic [4:0] OP_VT   = 5'd19;
    localparam logic [4:0] OP_DIV  = 5'd20;
    localparam logic [4:0] OP_STM  = 5'd21;
    localparam logic [4:0] OP_ST   = 5'd22;
    localparam logic [4:0] OP_TLM  = 5'd23;
    localparam logic [4:0] OP_TL   = 5'd24;
    localparam logic [4:0] OP_THM  = 5'd25;
    localparam logic [4:0] OP_ADV  = 5'd26;
    localparam logic [4:0] OP_PM   = 5'd27;
    localparam logic [4:0] OP_PO   = 5'd28;
    localparam logic [4:0] OP_TM   = 5'd29;
    localparam logic [4:0] OP_TO   = 5'd30;
    localparam logic [4:0] OP_EMIT = 5'd31;

    localparam logic [2:0] SEL_PAN_COS  = 3'd0;
    localparam logic [2:0] SEL_TILT_SIN = 3'd1;
    localparam logic [2:0] SEL_PAN_SIN  = 3'd2;
    localparam logic [2:0] SEL_TILT_COS = 3'd3;

    localparam logic [2:0] COEF_C1 = 3'd0;
    localparam logic [2:0] COEF_C3 = 3'd1;
    localparam logic [2:0] COEF_C5 = 3'd2;
    localparam logic [2:0] COEF_C7 = 3'd3;

    localparam int PC_W      = 7;
    localparam int SIN_LEN   = 13;
    localparam int SIN0_BASE = 0;
    localparam int SIN1_BASE = 17;
    localparam int SIN2_BASE = 45;
    localparam int SIN3_BASE = 60;
    localparam int PROG_LAST = 75;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] arg;
    } cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
    } dp_status_t;

    function automatic cmd_t sin_cmd(logic [3:0] j, logic [2:0] sel);
        cmd_t c;
        c.arg = 3'd0;
        case (j)
            4'd0:
            begin
                c.op  = OP_LOAD;
                c.arg = sel;
            end
            4'd1:    c.op = OP_USQ;
            4'd2:    c.op = OP_U2;
            4'd4:
            begin
                c.op  = OP_SSUB;
                c.arg = COEF_C7;
            end
            4'd6:
            begin
                c.op  = OP_SSUB;
                c.arg = COEF_C5;
            end
            4'd8:
            begin
                c.op  = OP_SSUB;
                c.arg = COEF_C3;
            end
            4'd10:
            begin
                c.op  = OP_SSUB;
                c.arg = COEF_C1;
            end
            4'd11:   c.op = OP_UMUL;
            4'd12:   c.op = OP_MAG;
            default: c.op = OP_SMUL;
        endcase
        return c;
    endfunction

    function automatic cmd_t prog(logic [PC_W-1:0] pc);
        cmd_t c;
        c.op  = OP_NOP;
        c.arg = 3'd0;
        if (pc < PC_W'(SIN0_BASE + SIN_LEN))
            c = sin_cmd(4'(pc - PC_W'(SIN0_BASE)), SEL_PAN_COS);
        else if (pc >= PC_W'(SIN1_BASE) && pc < PC_W'(SIN1_BASE + SIN_LEN))
            c = sin_cmd(4'(pc - PC_W'(SIN1_BASE)), SEL_TILT_SIN);
        else if (pc >= PC_W'(SIN2_BASE) && pc < PC_W'(SIN2_BASE + SIN_LEN))
            c = sin_cmd(4'(pc - PC_W'(SIN2_BASE)), SEL_PAN_SIN);
        else if (pc >= PC_W'(SIN3_BASE) && pc < PC_W'(SIN3_BASE + SIN_LEN))
            c = sin_cmd(4'(pc - PC_W'(SIN3_BASE)), SEL_TILT_COS);
        else
        begin
            case (pc)
                7'd13:   c.op = OP_DXM;
                7'd14:   c.op = OP_DX;
                7'd15:   c.op = OP_KM;
                7'd16:   c.op = OP_K;
                7'd30:   c.op = OP_DYM;
                7'd31:   c.op = OP_DY;
                7'd32:   c.op = OP_XX;
                7'd33:   c.op = OP_SUMX;
                7'd34:   c.op = OP_YY;
                7'd35:   c.op = OP_SUMY;
                7'd36:   c.op = OP_SQRT;
                7'd37:   c.op = OP_VT;
                7'd38:   c.op = OP_DIV;
                7'd39:   c.op = OP_STM;
                7'd40:   c.op = OP_ST;
                7'd41:   c.op = OP_TLM;
                7'd42:   c.op = OP_TL;
                7'd43:   c.op = OP_THM;
                7'd44:   c.op = OP_ADV;
                7'd58:   c.op = OP_PM;
                7'd59:   c.op = OP_PO;
                7'd73:   c.op = OP_TM;
                7'd74:   c.op = OP_TO;
                7'd75:   c.op = OP_EMIT;
                default: c.op = OP_NOP;
            endcase
        end
        return c;
    endfunction

    function automatic logic [31:0] coef(logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            COEF_C1: c = C1_Q30;
            COEF_C3: c = C3_Q30;
            COEF_C5: c = C5_Q30;
            COEF_C7: c = C7_Q30;
            default: c = C9_Q30;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] to_ang32(logic [PHASE_BITS-1:0] ph);
        logic [79:0] w;
        w = 80'(ph) << 32;
        return w[PHASE_BITS +: 32];
    endfunction

    // round half away from zero, then saturate to 18-bit signed
    function automatic logic [17:0] out_sat(logic [PROD_W-1:0] p, logic neg, int sh);
        logic [PROD_W:0] m;
        logic [17:0]     v;
        m = ({1'b0, p} + ((PROD_W+1)'(1) << (sh - 1))) >> sh;
        if (neg)
            v = (m > (PROD_W+1)'(131072)) ? 18'h20000 : 18'(~m + 1'b1);
        else
            v = (m > (PROD_W+1)'(131071)) ? 18'h1FFFF : m[17:0];
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/constant_speed_lissajous_scan_top.sv -----
// an accepted tick runs the microcode program, waits on the square root and the divider,
// and raises out_valid at the end, after any wait on out_stall
// a new tick is taken only once the last result is emitted; the square root,
// the divider and 76 microcode steps on one multiplier set the pace
// a tick of zero is taken while idle and gives no result
// reset: asynchronous, active low; phases clear to zero, registers take their defaults
`default_nettype none

module constant_speed_lissajous_scan_top
    import clscan_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        tick,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [17:0]      pan_goal,
    output logic [17:0]      tilt_goal,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    cmd_t       cmd;
    dp_status_t status;

    clscan_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    clscan_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pan_goal  (pan_goal),
        .tilt_goal (tilt_goal)
    );

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.sqrt_busy && status.div_busy))
        else $error("square root and divider busy together");

    a_quiet_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (status.sqrt_busy || status.div_busy) |-> (cmd.op == OP_NOP))
        else $error("command issued while a unit is busy");

    a_cmd_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NOP) |-> in_stall)
        else $error("command issued while idle");

    a_tick_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && tick) |=> in_stall)
        else $error("tick transfer did not start work");
`endif

endmodule

`default_nettype wire

// ----- rtl/clscan_datapath.sv -----
`default_nettype none

module clscan_datapath
    import clscan_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output dp_status_t       status,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output logic [17:0]      pan_goal,
    output logic [17:0]      tilt_goal
);

    logic [19:0] target_speed_reg;
    logic [15:0] frame_period_reg;
    logic [16:0] yaw_amplitude_reg;
    logic [19:0] tilt_frequency_reg;

    logic [PHASE_BITS-1:0] pan_phase_reg;
    logic [PHASE_BITS-1:0] tilt_phase_reg;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] tinc_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic [30:0] u_reg;
    logic [30:0] u2_reg;
    logic [1:0]  quad_reg;
    logic [31:0] s_reg;
    logic [30:0] mag_reg;
    logic        neg_reg;
    logic [25:0] dx_reg;
    logic [27:0] dy_reg;
    logic [19:0] k_reg;
    logic [SUM_W-1:0] sum_reg;
    logic        sat_reg;

    logic [SUM_W-1:0]   sq_x_reg;
    logic [SUM_W-1:0]   sq_r_reg;
    logic [SUM_W-1:0]   sq_bit_reg;
    logic               sq_busy_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic [SPEED_W-1:0] dv_rem_reg;
    logic [DIVD_W-1:0]  dv_q_reg;
    logic [DCNT_W-1:0]  dv_cnt_reg;
    logic               dv_busy_reg;

    logic [17:0] pan_stage_reg;
    logic [17:0] tilt_stage_reg;
    logic [17:0] pan_out_reg;
    logic [17:0] tilt_out_reg;

    logic [31:0]      ang;
    logic [SUM_W-1:0] sq_trial;
    logic [SPEED_W:0] dv_cat;
    logic [SPEED_W+1:0] dv_diff;
    logic [PHASE_BITS-1:0] sel_phase;
    logic [35:0] mag_raw;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_USQ:
            begin
                mul_a = MUL_A_W'(u_reg);
                mul_b = MUL_B_W'(u_reg);
            end
            OP_SMUL:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(u2_reg);
            end
            OP_UMUL:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = MUL_B_W'(u_reg);
            end
            OP_DXM, OP_PM:
            begin
                mul_a = MUL_A_W'(yaw_amplitude_reg);
                mul_b = MUL_B_W'(mag_reg);
            end
            OP_KM:
            begin
                mul_a = MUL_A_W'(PI4_Q30);
                mul_b = MUL_B_W'(tilt_frequency_reg);
            end
            OP_DYM:
            begin
                mul_a = MUL_A_W'(k_reg);
                mul_b = MUL_B_W'(mag_reg);
            end
            OP_XX:
            begin
                mul_a = MUL_A_W'(dx_reg);
                mul_b = MUL_B_W'(dx_reg);
            end
            OP_YY:
            begin
                mul_a = MUL_A_W'(dy_reg);
                mul_b = MUL_B_W'(dy_reg);
            end
            OP_VT:
            begin
                mul_a = MUL_A_W'(target_speed_reg);
                mul_b = MUL_B_W'(frame_period_reg);
            end
            OP_STM:
            begin
                mul_a = dv_q_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(INV2PI_Q32);
            end
            OP_TLM:
            begin
                mul_a = MUL_A_W'(tilt_frequency_reg[15:0]);
                mul_b = MUL_B_W'(step_reg);
            end
            OP_THM:
            begin
                mul_a = MUL_A_W'(tilt_frequency_reg[19:16]);
                mul_b = MUL_B_W'(step_reg);
            end
            OP_TM:
            begin
                mul_a = MUL_A_W'(PI4_Q30);
                mul_b = MUL_B_W'(mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.arg)
            SEL_PAN_COS, SEL_PAN_SIN: sel_phase = pan_phase_reg;
            default:                  sel_phase = tilt_phase_reg;
        endcase
        if (cmd.arg == SEL_PAN_COS || cmd.arg == SEL_TILT_COS)
            ang = to_ang32(sel_phase) + Q30_ONE;
        else
            ang = to_ang32(sel_phase);
    end

    assign mag_raw  = prod_reg[65:30];
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign dv_cat   = {dv_rem_reg, dv_q_reg[DIVD_W-1]};
    assign dv_diff  = {1'b0, dv_cat} - (SPEED_W+2)'(speed_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // microcoded register transfers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                quad_reg <= ang[31:30];
                if (ang[30])
                    u_reg <= Q30_ONE[30:0] - {1'b0, ang[29:0]};
                else
                    u_reg <= {1'b0, ang[29:0]};
            end
            OP_U2:
            begin
                u2_reg <= prod_reg[60:30];
                s_reg  <= C9_Q30;
            end
            OP_SSUB: s_reg <= coef(cmd.arg) - prod_reg[61:30];
            OP_MAG:
            begin
                if (mag_raw > 36'(Q30_ONE))
                    mag_reg <= Q30_ONE[30:0];
                else
                    mag_reg <= mag_raw[30:0];
                neg_reg <= quad_reg[1] && (mag_raw != 36'd0);
            end
            OP_DX:   dx_reg  <= prod_reg[47:22];
            OP_K:    k_reg   <= prod_reg[49:30];
            OP_DY:   dy_reg  <= prod_reg[49:22];
            OP_SUMX: sum_reg <= prod_reg[SUM_W-1:0];
            OP_SUMY: sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
            OP_STM:  sat_reg <= (dv_q_reg >= PI_Q32);
            OP_ST:
            begin
                if (sat_reg)
                    step_reg <= PHASE_BITS'(1) << (PHASE_BITS - 1);
                else
                    step_reg <= prod_reg[64-PHASE_BITS +: PHASE_BITS];
            end
            OP_TL:   tinc_reg <= prod_reg[16 +: PHASE_BITS];
            OP_PO:   pan_stage_reg  <= out_sat(prod_reg, neg_reg, PAN_SH);
            OP_TO:   tilt_stage_reg <= out_sat(prod_reg, neg_reg, TILT_SH);
            OP_EMIT:
            begin
                pan_out_reg  <= pan_stage_reg;
                tilt_out_reg <= tilt_stage_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_phase_reg  <= '0;
            tilt_phase_reg <= '0;
        end
        else if (cmd.op == OP_ADV)
        begin
            pan_phase_reg  <= pan_phase_reg + step_reg;
            tilt_phase_reg <= tilt_phase_reg + tinc_reg + prod_reg[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg   <= TARGET_SPEED_RST;
            frame_period_reg   <= FRAME_PERIOD_RST;
            yaw_amplitude_reg  <= YAW_AMPLITUDE_RST;
            tilt_frequency_reg <= TILT_FREQUENCY_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_SPEED:   target_speed_reg   <= cfg_data;
                REG_FRAME_PERIOD:   frame_period_reg   <= cfg_data[15:0];
                REG_YAW_AMPLITUDE:  yaw_amplitude_reg  <= cfg_data[16:0];
                REG_TILT_FREQUENCY: tilt_frequency_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // bit-pair square root, one pair per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_busy_reg <= 1'b0;
        else if (cmd.op == OP_SQRT)
            sq_busy_reg <= 1'b1;
        else if (sq_busy_reg && sq_bit_reg[0])
            sq_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SQRT)
        begin
            sq_x_reg   <= sum_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= SUM_W'(1) << (SUM_W - 2);
        end
        else if (sq_busy_reg)
        begin
            if (sq_x_reg >= sq_trial)
            begin
                sq_x_reg <= sq_x_reg - sq_trial;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.op == OP_VT)
            speed_reg <= sq_r_reg[SPEED_W-1:0];
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_busy_reg <= 1'b0;
        else if (cmd.op == OP_DIV)
            dv_busy_reg <= (speed_reg != '0);
        else if (dv_busy_reg && dv_cnt_reg == '0)
            dv_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV)
        begin
            dv_rem_reg <= '0;
            dv_cnt_reg <= DCNT_W'(DIVD_W - 1);
            if (speed_reg != '0)
                dv_q_reg <= {prod_reg[35:0], 24'd0};
            else
                dv_q_reg <= DIVD_W'({frame_period_reg, 16'd0});
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
            if (!dv_diff[SPEED_W+1])
            begin
                dv_rem_reg <= dv_diff[SPEED_W-1:0];
                dv_q_reg   <= {dv_q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_cat[SPEED_W-1:0];
                dv_q_reg   <= {dv_q_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign status.sqrt_busy = sq_busy_reg;
    assign status.div_busy  = dv_busy_reg;
    assign pan_goal         = pan_out_reg;
    assign tilt_goal        = tilt_out_reg;

endmodule

`default_nettype wire

// ----- rtl/clscan_ctrl.sv -----
`default_nettype none

module clscan_ctrl
    import clscan_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       tick,
    output logic            out_valid,
    input  wire logic       out_stall,
    output cmd_t            cmd,
    input  wire dp_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    cmd_t            cur;
    logic            emit_block;

    assign cur        = prog(pc_reg);
    assign emit_block = out_valid_reg && out_stall;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NOP;
        cmd.arg        = 3'd0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && tick)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (cur.op == OP_EMIT)
                begin
                    if (!emit_block)
                    begin
                        cmd            = cur;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd     = cur;
                    pc_next = pc_reg + 1'b1;
                    if (cur.op == OP_SQRT || cur.op == OP_DIV)
                        state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!status.sqrt_busy && !status.div_busy)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    import clscan_pkg::*;

    localparam int LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        tick;
    logic        out_valid;
    logic        out_stall;
    logic [17:0] pan_goal;
    logic [17:0] tilt_goal;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    logic [19:0] speed_reg;
    logic [15:0] frame_reg;
    logic [16:0] amp_reg;
    logic [19:0] freq_reg;
    logic [31:0] pan_ph;
    logic [31:0] tilt_ph;

    logic [35:0] target_q[$];
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          cycles;
    int          ticks_sent;
    int          results_seen;

    constant_speed_lissajous_scan_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .tick(tick),
        .out_valid(out_valid), .out_stall(out_stall),
        .pan_goal(pan_goal), .tilt_goal(tilt_goal),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] sine_quarter(logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] s;
        u2 = (u * u) >> 30;
        s = 64'(C9_Q30);
        s = 64'(C7_Q30) - ((s * u2) >> 30);
        s = 64'(C5_Q30) - ((s * u2) >> 30);
        s = 64'(C3_Q30) - ((s * u2) >> 30);
        s = 64'(C1_Q30) - ((s * u2) >> 30);
        s = (s * u) >> 30;
        return (s > 64'(Q30_ONE)) ? 64'(Q30_ONE) : s;
    endfunction

    // returns {negative, magnitude}
    function automatic logic [64:0] sine_of(logic [31:0] a);
        logic [63:0] r;
        logic [63:0] m;
        r = {34'd0, a[29:0]};
        if (a[30])
            r = 64'(Q30_ONE) - r;
        m = sine_quarter(r);
        return {a[31] && (m != 0), m};
    endfunction

    function automatic logic [64:0] cosine_of(logic [31:0] a);
        return sine_of(a + 32'h4000_0000);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [17:0] round_sat(logic [63:0] mag, logic neg, int sh);
        logic [63:0] m;
        m = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg)
            return (m > 64'd131072) ? 18'h20000 : 18'(-m);
        return (m > 64'd131071) ? 18'h1FFFF : m[17:0];
    endfunction

    task automatic advance_scan();
        logic [64:0]  cs;
        logic [64:0]  ss;
        logic [63:0]  dx;
        logic [63:0]  dy;
        logic [63:0]  k;
        logic [63:0]  spd;
        logic [63:0]  stq;
        logic [127:0] wide;
        logic [63:0]  stp;
        logic [63:0]  tinc;
        logic [17:0]  pan_exp;
        logic [17:0]  tilt_exp;
        cs = cosine_of(pan_ph);
        ss = sine_of(tilt_ph);
        dx = (64'(amp_reg) * cs[63:0]) >> 22;
        k = (64'(PI4_Q30) * 64'(freq_reg)) >> 30;
        dy = (k * ss[63:0]) >> 22;
        spd = root_floor(dx * dx + dy * dy);
        if (spd > 0)
            stq = ((64'(speed_reg) * 64'(frame_reg)) << 24) / spd;
        else
            stq = 64'(frame_reg) << 16;
        if (stq >= 64'(PI_Q32))
            stp = 64'h8000_0000;
        else
        begin
            wide = 128'(stq) * 128'(INV2PI_Q32);
            stp = wide[95:32];
        end
        tinc = 64'(freq_reg >> 16) * stp + ((64'(freq_reg[15:0]) * stp) >> 16);
        pan_ph = pan_ph + stp[31:0];
        tilt_ph = tilt_ph + tinc[31:0];
        ss = sine_of(pan_ph);
        cs = cosine_of(tilt_ph);
        pan_exp = round_sat(64'(amp_reg) * ss[63:0], ss[64], PAN_SH);
        tilt_exp = round_sat(64'(PI4_Q30) * cs[63:0], cs[64], TILT_SH);
        target_q.insert(target_q.size(), {pan_exp, tilt_exp});
    endtask

    task automatic send_tick(logic t);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            tick <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (t)
        begin
            advance_scan();
            ticks_sent++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        tick <= 1'b0;
        while (target_q.size() != 0)
            @(posedge clk);
        repeat (250)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TARGET_SPEED:   speed_reg = val;
            REG_FRAME_PERIOD:   frame_reg = val[15:0];
            REG_YAW_AMPLITUDE:  amp_reg = val[16:0];
            REG_TILT_FREQUENCY: freq_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [19:0] v, logic [15:0] t, logic [16:0] a, logic [19:0] f);
        write_reg(REG_TARGET_SPEED, v);
        write_reg(REG_FRAME_PERIOD, 20'(t));
        write_reg(REG_YAW_AMPLITUDE, 20'(a));
        write_reg(REG_TILT_FREQUENCY, f);
    endtask

    task automatic set_idling(int s, int r);
        send_idle = s;
        recv_idle = r;
    endtask

    task automatic test_defaults();
        repeat (6)
            send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_extremes();
        // zero amplitude and zero frequency force zero speed
        set_all(20'd65536, 16'd1311, 17'd0, 20'd0);
        repeat (3)
            send_tick(1'b1);
        set_all(20'hFFFFF, 16'hFFFF, 17'h1FFFF, 20'hFFFFF);
        repeat (3)
            send_tick(1'b1);
        set_all(20'd0, 16'd1, 17'd102944, 20'd1);
        repeat (3)
            send_tick(1'b1);
        set_all(20'd1, 16'hFFFF, 17'd1, 20'h10000);
        repeat (3)
            send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                set_all(20'($urandom), 16'($urandom_range(65535, 1)),
                        17'($urandom_range(102944)), 20'($urandom));
            send_tick(($urandom_range(9) != 0) ? 1'b1 : 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_idle > 0 && $urandom_range(99) < recv_idle)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (target_q.size() == 0)
            begin
                $display("%0t: unexpected transfer pan %0d tilt %0d", $time,
                         $signed(pan_goal), $signed(tilt_goal));
                errors++;
            end
            else
            begin
                logic [35:0] e;
                e = target_q.pop_front();
                if (pan_goal !== e[35:18])
                begin
                    $display("%0t: pan_goal expected %0d actual %0d", $time,
                             $signed(e[35:18]), $signed(pan_goal));
                    errors++;
                end
                if (tilt_goal !== e[17:0])
                begin
                    $display("%0t: tilt_goal expected %0d actual %0d", $time,
                             $signed(e[17:0]), $signed(tilt_goal));
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        tick = 1'b0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = 2'd0;
        cfg_data = 20'd0;
        errors = 0;
        cycles = 0;
        ticks_sent = 0;
        results_seen = 0;
        send_idle = 0;
        recv_idle = 0;
        speed_reg = 20'd65536;
        frame_reg = 16'd1311;
        amp_reg = 17'd68629;
        freq_reg = 20'd197535;
        pan_ph = 0;
        tilt_ph = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_extremes();
        test_random(130);
        set_idling(45, 0);
        test_random(120);
        set_idling(0, 45);
        test_random(120);
        set_idling(7, 7);
        test_random(130);
        set_idling(0, 0);
        wait_idle();

        $display("covered %0d ticks, %0d scan targets checked, with idle, stall and zero-speed",
                 ticks_sent, results_seen);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
